// ===== rtl/snlcd_pkg.sv =====
// Package for the signed number to segment LCD block: request and result
// types, digit codes and the segment remap. No dependencies.
package snlcd_pkg;

  localparam int BIN_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int NBYTES     = 6;
  localparam int DIGITS_DEF = 6;
  localparam int SYM_BIT    = 4;

  localparam logic [6:0] MINUS_CODE = 7'h40;

  typedef struct packed {
    logic signed [31:0] number;
    logic [1:0]         point_position;
  } in_t;

  typedef struct packed {
    logic [7:0] mem_byte_0;
    logic [7:0] mem_byte_1;
    logic [7:0] mem_byte_2;
    logic [7:0] mem_byte_3;
    logic [7:0] mem_byte_4;
    logic [7:0] mem_byte_5;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bcd_stat_t;

  function automatic logic [6:0] seg_code(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'd0:    c = 7'h3F;
      4'd1:    c = 7'h06;
      4'd2:    c = 7'h5B;
      4'd3:    c = 7'h4F;
      4'd4:    c = 7'h66;
      4'd5:    c = 7'h6D;
      4'd6:    c = 7'h7D;
      4'd7:    c = 7'h07;
      4'd8:    c = 7'h7F;
      4'd9:    c = 7'h6F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Segments a..g go to byte bits 7,6,5,0,1,3,2; bit 4 stays clear.
  function automatic logic [7:0] remap(input logic [6:0] c);
    return {c[0], c[1], c[2], 1'b0, c[5], c[6], c[4], c[3]};
  endfunction

endpackage

// ===== rtl/snlcd_bcd.sv =====
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on snlcd_pkg.
module snlcd_bcd (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [snlcd_pkg::BIN_W-1:0]         mag,
  output logic [4*snlcd_pkg::BCD_DIGITS-1:0]  bcd,
  output snlcd_pkg::bcd_stat_t                stat
);

  localparam int CNT_W = $clog2(snlcd_pkg::BIN_W);
  localparam int BCD_W = 4 * snlcd_pkg::BCD_DIGITS;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SHIFT = 1'b1;

  logic                        state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [snlcd_pkg::BIN_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]            bcd_r, bcd_nxt;
  logic                        done_r, done_nxt;
  logic [BCD_W-1:0]            adj;

  // Add 3 to every digit of five or more, then shift one bit in.
  always_comb begin
    adj = bcd_r;
    for (int d = 0; d < snlcd_pkg::BCD_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    done_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          bin_nxt   = mag;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        bcd_nxt = {adj[BCD_W-2:0], bin_r[snlcd_pkg::BIN_W-1]};
        bin_nxt = {bin_r[snlcd_pkg::BIN_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(snlcd_pkg::BIN_W - 1)) begin
          state_nxt = ST_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd       = bcd_r;
  assign stat.busy = (state_r == ST_SHIFT);
  assign stat.done = done_r;

endmodule

// ===== rtl/signed_number_to_segment_lcd.sv =====
// Top level of the signed number to segment LCD block.
// Depends on snlcd_pkg and snlcd_bcd.
//
// A request (number, point position) is taken at a clock edge with start high
// and busy low. The magnitude goes through a shift-and-add-3 BCD converter
// that handles one bit per cycle over 32 shift steps; the result strobe
// out_valid, registered from the converter's done flag, is high for one cycle
// and carries the six LCD memory bytes. The receiver cannot stall; take
// the bytes in the strobe cycle. busy drops at the edge that raises the
// strobe, so a new request may be issued in the strobe cycle and is taken at
// the edge that ends it; a new request is not taken while one converts.
// Digits fill positions from the highest byte (mem_byte_5) downward, at least
// one digit is shown, and a minus sign takes the next free position; digits
// or a sign at or beyond DIGITS positions (or beyond six bytes) are dropped.
// The most negative number is shown as its unsigned magnitude.
module signed_number_to_segment_lcd #(
  parameter int DIGITS = snlcd_pkg::DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  snlcd_pkg::in_t   in_req,
  output logic             out_valid,
  output snlcd_pkg::out_t  out_res
);

  localparam int BCD_W = 4 * snlcd_pkg::BCD_DIGITS;
  localparam int ND_W  = $clog2(snlcd_pkg::BCD_DIGITS + 1);

  logic                        busy_r, busy_nxt;
  logic                        neg_r;
  logic [1:0]                  dp_r;
  logic                        accept;
  logic [snlcd_pkg::BIN_W-1:0] mag;
  logic [BCD_W-1:0]            bcd;
  snlcd_pkg::bcd_stat_t        stat;
  logic [ND_W-1:0]             nd;
  logic [8*snlcd_pkg::NBYTES-1:0] bytes;
  logic                        out_valid_r;
  snlcd_pkg::out_t             out_r;

  assign accept = start && !busy_r;

  // Two's complement magnitude; -2^31 wraps to 2^31 as unsigned.
  assign mag = in_req.number[31] ? (32'd0 - in_req.number) : in_req.number;

  snlcd_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .mag   (mag),
    .bcd   (bcd),
    .stat  (stat)
  );

  // Count significant digits, at least one.
  always_comb begin
    nd = ND_W'(1);
    for (int d = 1; d < snlcd_pkg::BCD_DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        nd = ND_W'(d + 1);
      end
    end
  end

  // Build the byte image: position p lands in byte 5-p.
  always_comb begin
    bytes = '0;
    for (int p = 0; p < snlcd_pkg::NBYTES; p++) begin
      if (p < DIGITS) begin
        if (ND_W'(p) < nd) begin
          bytes[8*p +: 8] = snlcd_pkg::remap(snlcd_pkg::seg_code(bcd[4*p +: 4]));
        end else if (neg_r && (ND_W'(p) == nd)) begin
          bytes[8*p +: 8] = snlcd_pkg::remap(snlcd_pkg::MINUS_CODE);
        end
      end
    end
    // Point bit: position point_position-1, i.e. byte 6-point_position.
    if (dp_r != 2'd0) begin
      bytes[8*(dp_r - 2'd1) + snlcd_pkg::SYM_BIT] = 1'b1;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (stat.done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= stat.done;
    end
    // Hold sign and point for the whole conversion.
    if (accept) begin
      neg_r <= in_req.number[31];
      dp_r  <= in_req.point_position;
    end
    if (stat.done) begin
      out_r.mem_byte_0 <= bytes[8*5 +: 8];
      out_r.mem_byte_1 <= bytes[8*4 +: 8];
      out_r.mem_byte_2 <= bytes[8*3 +: 8];
      out_r.mem_byte_3 <= bytes[8*2 +: 8];
      out_r.mem_byte_4 <= bytes[8*1 +: 8];
      out_r.mem_byte_5 <= bytes[8*0 +: 8];
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && stat.busy))
    else $error("request accepted but converter not running");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result strobe");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_sym_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_res.mem_byte_0[snlcd_pkg::SYM_BIT] &&
                   !out_res.mem_byte_1[snlcd_pkg::SYM_BIT] &&
                   !out_res.mem_byte_2[snlcd_pkg::SYM_BIT]))
    else $error("symbol bit set in bytes 0 to 2");
`endif

endmodule

// ===== dv/snlcd_checker.sv =====
`timescale 1ns / 1ps
// Checker for signed_number_to_segment_lcd: watches the request and result
// channels, predicts each LCD image and compares it byte by byte.
// Depends on snlcd_pkg.
module snlcd_checker #(
  parameter int DIGITS = snlcd_pkg::DIGITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  snlcd_pkg::in_t  in_req,
  input  logic            out_valid,
  input  snlcd_pkg::out_t out_res,
  input  logic            end_check,
  output int              mismatch_count,
  output int              pending_results
);

  localparam logic [6:0] DIGIT_SEG [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };
  // Byte bit that receives each segment a..g.
  localparam int SEG_TO_BIT [7] = '{7, 6, 5, 0, 1, 3, 2};

  snlcd_pkg::out_t expected_lcd_q[$];
  snlcd_pkg::out_t want;
  bit              leftovers_checked = 1'b0;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  function automatic logic [7:0] place_segments(input logic [6:0] code);
    logic [7:0] b;
    b = 8'h00;
    for (int i = 0; i < 7; i++)
      if (code[i]) b[SEG_TO_BIT[i]] = 1'b1;
    return b;
  endfunction

  function automatic snlcd_pkg::out_t lcd_image(input snlcd_pkg::in_t req);
    logic [7:0]      mem [snlcd_pkg::NBYTES];
    logic [31:0]     raw;
    logic [31:0]     mag;
    logic            neg;
    int              pos;
    snlcd_pkg::out_t img;
    foreach (mem[i]) mem[i] = 8'h00;
    raw = req.number;
    neg = raw[31];
    // The most negative number wraps to 2^31, read as unsigned.
    mag = neg ? (32'd0 - raw) : raw;
    pos = 0;
    do begin
      if (pos < DIGITS && pos < snlcd_pkg::NBYTES)
        mem[snlcd_pkg::NBYTES - 1 - pos] =
          place_segments(DIGIT_SEG[int'(mag % 32'd10)]);
      mag = mag / 32'd10;
      pos++;
    end while (mag != 32'd0);
    // Drop the sign when it has no position left.
    if (neg && pos < DIGITS && pos < snlcd_pkg::NBYTES)
      mem[snlcd_pkg::NBYTES - 1 - pos] = place_segments(snlcd_pkg::MINUS_CODE);
    if (req.point_position != 2'd0)
      mem[snlcd_pkg::NBYTES - int'(req.point_position)][snlcd_pkg::SYM_BIT] = 1'b1;
    img.mem_byte_0 = mem[0];
    img.mem_byte_1 = mem[1];
    img.mem_byte_2 = mem[2];
    img.mem_byte_3 = mem[3];
    img.mem_byte_4 = mem[4];
    img.mem_byte_5 = mem[5];
    return img;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_byte(input string name, input logic [7:0] got,
                            input logic [7:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %02h want %02h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_lcd_q.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          want = expected_lcd_q.pop_front();
          check_byte("mem_byte_0", out_res.mem_byte_0, want.mem_byte_0);
          check_byte("mem_byte_1", out_res.mem_byte_1, want.mem_byte_1);
          check_byte("mem_byte_2", out_res.mem_byte_2, want.mem_byte_2);
          check_byte("mem_byte_3", out_res.mem_byte_3, want.mem_byte_3);
          check_byte("mem_byte_4", out_res.mem_byte_4, want.mem_byte_4);
          check_byte("mem_byte_5", out_res.mem_byte_5, want.mem_byte_5);
        end
      end
      if (start && busy === 1'b0)
        expected_lcd_q.push_back(lcd_image(in_req));
      if (end_check && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_lcd_q.size() != 0)
          report_mismatch($sformatf("%0d requests never answered",
                                    expected_lcd_q.size()));
      end
    end
    pending_results = expected_lcd_q.size();
  end

endmodule

// ===== dv/tb_signed_number_to_segment_lcd.sv =====
`timescale 1ns / 1ps
// Testbench top for signed_number_to_segment_lcd: drives directed and random
// requests and gives the verdict. Depends on snlcd_pkg and snlcd_checker.
module tb_signed_number_to_segment_lcd;

  localparam int RANDOM_REQUESTS = 400;
  // Bound for the slowest run: ~420 requests plus random idle gaps.
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 40;

  logic            clk;
  logic            rst_n     = 1'b0;
  logic            start     = 1'b0;
  logic            busy;
  snlcd_pkg::in_t  in_req    = '0;
  logic            out_valid;
  snlcd_pkg::out_t out_res;
  logic            end_check = 1'b0;
  int              mismatches;
  int              pending;
  int              cycle_count = 0;

  signed_number_to_segment_lcd u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  snlcd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req          (in_req),
    .out_valid       (out_valid),
    .out_res         (out_res),
    .end_check       (end_check),
    .mismatch_count  (mismatches),
    .pending_results (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Called at a rising edge. Present the request and hold it until an edge
  // with busy low takes it. busy only moves at rising edges, so read it at
  // the falling edge before.
  task automatic send_request(input snlcd_pkg::in_t req);
    in_req <= req;
    start  <= 1'b1;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  // Drop start for a few cycles.
  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic snlcd_pkg::in_t make_request(input logic signed [31:0] value,
                                                  input logic [1:0] point);
    snlcd_pkg::in_t r;
    r.number         = value;
    r.point_position = point;
    return r;
  endfunction

  // Spread magnitudes over every decimal length so that short numbers, the
  // five and six digit sign boundary and overflowing lengths all show up.
  function automatic snlcd_pkg::in_t random_request();
    snlcd_pkg::in_t r;
    int unsigned    ndigits;
    int unsigned    lim;
    int unsigned    mag;
    ndigits = $urandom_range(1, 10);
    if (ndigits == 10) begin
      r.number = $urandom;
    end else begin
      lim = 1;
      repeat (ndigits) lim *= 10;
      mag = $urandom % lim;
      r.number = $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
    end
    r.point_position = 2'($urandom_range(0, 3));
    return r;
  endfunction

  snlcd_pkg::in_t directed_reqs [$];

  initial begin
    directed_reqs = '{
      make_request(0, 2'd0),            // zero still shows one digit
      make_request(1, 2'd1),
      make_request(-1, 2'd2),
      make_request(9, 2'd3),
      make_request(10, 2'd0),
      make_request(123456, 2'd1),       // fills all six positions
      make_request(7890, 2'd2),
      make_request(99999, 2'd3),
      make_request(-99999, 2'd0),       // sign takes the last position
      make_request(100000, 2'd1),
      make_request(-100000, 2'd2),      // no room left for the sign
      make_request(999999, 2'd3),
      make_request(1000000, 2'd0),      // top digit falls off
      make_request(-1234567, 2'd1),
      make_request(32'sh7FFFFFFF, 2'd2),
      make_request(32'sh80000000, 2'd3), // most negative number
      make_request(32'sh80000001, 2'd0),
      make_request(0, 2'd3),
      make_request(-5, 2'd1),
      make_request(-42, 2'd3)
    };

    // Hold reset low from the start, then release it once.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_reqs[i]) begin
      if (i == 10) idle_cycles($urandom_range(1, 40));
      send_request(directed_reqs[i]);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 120 || n == 320) wait_for_drain();
      // Keep requests back to back from 150 to 260; elsewhere idle now and
      // then with gaps long enough to land on every conversion step.
      if ((n < 150 || n >= 260) && $urandom_range(0, 99) < 6)
        idle_cycles($urandom_range(1, 40));
      send_request(random_request());
    end
    start <= 1'b0;

    // Wait for the last results, then give the block time to show anything
    // stray before checking for leftovers.
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
